// File: hw/rtl/tdpc_pkg.sv
// Shared constants and types for the trial-division prime counter.
`timescale 1ns / 1ps

package tdpc_pkg;

	// Default widths of the tested value and of the prime count.
	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF = 16;

	// Handshake from the sequencer to the remainder unit.
	typedef struct packed {
		logic start;
	} tdpc_rem_req_t;

	// Status from the remainder unit back to the sequencer.
	typedef struct packed {
		logic done;
		logic rem_zero;
	} tdpc_rem_rsp_t;

	// Verdict handed from the sequencer to the output stage.
	typedef struct packed {
		logic valid;
		logic is_prime;
		logic last;
	} tdpc_res_t;

endpackage

// File: hw/rtl/tdpc_rem_unit.sv
// Bit-serial restoring remainder unit: one compare and subtract per cycle.
`timescale 1ns / 1ps

module tdpc_rem_unit #(
	parameter int VALUE_BITS = tdpc_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tdpc_pkg::tdpc_rem_req_t       req,
	input  logic [VALUE_BITS-1:0]         dividend,
	input  logic [VALUE_BITS/2+1:0]       divisor,
	output tdpc_pkg::tdpc_rem_rsp_t       rsp
);
	import tdpc_pkg::*;

	localparam int DIV_BITS = VALUE_BITS / 2 + 2;
	localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

	logic [DIV_BITS-1:0]   rem_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIV_BITS:0]     trial;
	logic [DIV_BITS:0]     diff;
	logic                  fits;

	// Partial remainder shifted left with the next dividend bit, then one trial subtraction.
	assign trial = {rem_q, shift_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	// Control: counts one step per dividend bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_BITS'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: the remainder always stays below the divisor, so it fits DIV_BITS.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= '0;
			shift_q <= dividend;
		end else if (busy_q) begin
			shift_q <= shift_q << 1;
			if (fits) begin
				rem_q <= diff[DIV_BITS-1:0];
			end else begin
				rem_q <= trial[DIV_BITS-1:0];
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.rem_zero = (rem_q == '0);

endmodule

// File: hw/rtl/tdpc_seq.sv
// Sequencer that steps the trial divisor and its square and decides primality.
`timescale 1ns / 1ps

module tdpc_seq #(
	parameter int VALUE_BITS = tdpc_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic                          last_of_set,
	output tdpc_pkg::tdpc_rem_req_t       rem_req,
	output logic [VALUE_BITS-1:0]         rem_dividend,
	output logic [VALUE_BITS/2+1:0]       rem_divisor,
	input  tdpc_pkg::tdpc_rem_rsp_t       rem_rsp,
	output tdpc_pkg::tdpc_res_t           res,
	input  logic                          res_ready
);
	import tdpc_pkg::*;

	localparam int DIV_BITS = VALUE_BITS / 2 + 2;
	localparam int SQ_BITS  = VALUE_BITS + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [DIV_BITS-1:0]   d_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic                  prime_q;
	logic                  last_q;
	logic                  start_q;
	logic                  sq_above;

	// The divisor square is kept one bit wider than the value, so the bound never wraps.
	assign sq_above = sq_q > {1'b0, v_q};

	// State, divisor tracking and verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			prime_q <= 1'b0;
			last_q  <= 1'b0;
			v_q     <= '0;
			d_q     <= '0;
			sq_q    <= '0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						v_q    <= value;
						last_q <= last_of_set;
						d_q    <= DIV_BITS'(3);
						sq_q   <= SQ_BITS'(9);
						priority if (value[VALUE_BITS-1] || (value[VALUE_BITS-1:1] == '0)) begin
							// Negative, zero or one.
							prime_q <= 1'b0;
							state_q <= ST_DONE;
						end else if (!value[0]) begin
							// Even values: only two is prime.
							prime_q <= (value == VALUE_BITS'(2));
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (sq_above) begin
						prime_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_rsp.done) begin
						if (rem_rsp.rem_zero) begin
							prime_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							// Next odd divisor: (d + 2)^2 = d^2 + 4d + 4.
							d_q     <= d_q + DIV_BITS'(2);
							sq_q    <= sq_q + (SQ_BITS'(d_q) << 2) + SQ_BITS'(4);
							state_q <= ST_CHECK;
						end
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign rem_req.start = start_q;
	assign rem_dividend  = v_q;
	assign rem_divisor   = d_q;
	assign res.valid     = (state_q == ST_DONE);
	assign res.is_prime  = prime_q;
	assign res.last      = last_q;

endmodule

// File: hw/rtl/trial_division_prime_counter.sv
// Top level of the trial-division prime counter: sequencer, remainder unit and output stage.
`timescale 1ns / 1ps

// Tests each signed value for primality by trial division and returns the verdict with the
// running count of primes in the current set, saturating at 2^COUNT_BITS - 1 and cleared after
// the transaction that carries tlast. Negative values, zero, one and all even values are settled
// directly, without trial division. Odd values are tried against the odd divisors 3, 5, 7 and
// so on while the divisor squared does not exceed the value; each divisor takes one pass through
// the bit-serial remainder unit. The input is not ready while an item is being tested; a finished
// result waits in the output register, so the next item can be taken as soon as the previous
// verdict has moved there.
module trial_division_prime_counter #(
	parameter int VALUE_BITS = tdpc_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = tdpc_pkg::COUNT_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// Fields from bit 0: value (VALUE_BITS, signed), zero fill.
	input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// last_of_set.
	input  logic                                    s_tlast,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// Fields from bit 0: is_prime (1), prime_count (COUNT_BITS), zero fill.
	output logic [((COUNT_BITS + 8) / 8) * 8 - 1:0] m_tdata,
	// set_done.
	output logic                                    m_tlast
);
	import tdpc_pkg::*;

	localparam int OUT_BITS = ((COUNT_BITS + 8) / 8) * 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	tdpc_rem_req_t            rem_req;
	tdpc_rem_rsp_t            rem_rsp;
	tdpc_res_t                res;
	logic                     res_ready;
	logic [VALUE_BITS-1:0]    rem_dividend;
	logic [VALUE_BITS/2+1:0]  rem_divisor;
	logic [COUNT_BITS-1:0]    count_q;
	logic [COUNT_BITS-1:0]    count_next;
	logic [COUNT_BITS-1:0]    m_count_q;
	logic                     m_prime_q;
	logic                     m_last_q;
	logic                     m_valid_q;
	logic                     res_take;

	tdpc_seq #(
		.VALUE_BITS(VALUE_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.value       (s_tdata[VALUE_BITS-1:0]),
		.last_of_set (s_tlast),
		.rem_req     (rem_req),
		.rem_dividend(rem_dividend),
		.rem_divisor (rem_divisor),
		.rem_rsp     (rem_rsp),
		.res         (res),
		.res_ready   (res_ready)
	);

	tdpc_rem_unit #(
		.VALUE_BITS(VALUE_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (rem_req),
		.dividend(rem_dividend),
		.divisor (rem_divisor),
		.rsp     (rem_rsp)
	);

	// The output register takes a verdict when it is empty or being emptied.
	assign res_ready  = !m_valid_q || m_tready;
	assign res_take   = res.valid && res_ready;
	assign count_next = (res.is_prime && (count_q != COUNT_MAX)) ?
		count_q + COUNT_BITS'(1) : count_q;

	// Running count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (res_take) begin
				count_q   <= res.last ? '0 : count_next;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (res_take) begin
			m_count_q <= count_next;
			m_prime_q <= res.is_prime;
			m_last_q  <= res.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_BITS'({m_count_q, m_prime_q});
	assign m_tlast  = m_last_q;

endmodule

// File: hw/rtl/tdpc_checker.sv
// Port-level checks for the trial-division prime counter, bound to the top level.
`timescale 1ns / 1ps

module tdpc_checker #(
	parameter int VALUE_BITS = tdpc_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = tdpc_pkg::COUNT_BITS_DEF
) (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    s_tvalid,
	input logic                                    s_tready,
	input logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input logic                                    s_tlast,
	input logic                                    m_tvalid,
	input logic                                    m_tready,
	input logic [((COUNT_BITS + 8) / 8) * 8 - 1:0] m_tdata,
	input logic                                    m_tlast
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// One item at a time: the input closes right after a transaction.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready straight after a transaction");

	// A prime verdict always carries a count of at least one.
	a_prime_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> (m_tdata[COUNT_BITS:1] != '0))
		else $error("prime result with zero count");

	// The padding bits of the result stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata >> (COUNT_BITS + 1)) == '0))
		else $error("result padding not zero");

endmodule

bind trial_division_prime_counter tdpc_checker #(
	.VALUE_BITS(VALUE_BITS),
	.COUNT_BITS(COUNT_BITS)
) u_tdpc_checker (.*);
